// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Widths, types and helper functions of the Sierpinski pixel classifier.
// ----------------------------------------------------------------------------
package spc_pkg;
	localparam int FRAC_BITS  = 12;
	localparam int PIXEL_BITS = 11;
	localparam int VERT_W     = PIXEL_BITS + FRAC_BITS;
	localparam int MAX_DEPTH  = 12;
	localparam int DEPTH_W    = 4;
	localparam int DIFF_W     = VERT_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SUM_W      = PROD_W + 3;
	localparam int CFG_DW     = 32;
	localparam int CFG_AW     = 5;

	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

	typedef logic [VERT_W-1:0]     coord_t;
	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef logic [DEPTH_W-1:0]    depth_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vert_t;

	typedef vert_t [2:0] trgl_t;

	// Control that travels down the chain with each pixel.
	typedef struct packed {
		logic   valid;
		logic   alive;
		depth_t left;
		pix_t   px;
		pix_t   py;
	} lvl_ctl_t;

	typedef enum logic [2:0] {
		REG_AX, REG_AY, REG_BX, REG_BY, REG_CX, REG_CY, REG_DEPTH
	} reg_idx_t;

	function automatic vert_t midpoint(vert_t u, vert_t v);
		logic [VERT_W:0] sx;
		logic [VERT_W:0] sy;
		vert_t m;
		sx = {1'b0, u.x} + {1'b0, v.x};
		sy = {1'b0, u.y} + {1'b0, v.y};
		m.x = sx[VERT_W:1];
		m.y = sy[VERT_W:1];
		return m;
	endfunction

	function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
		coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
		coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction
endpackage

// ===== sv/spc_if.sv =====
// ----------------------------------------------------------------------------
// spc_pix_if / spc_res_if
// Valid/ready channels for pixel requests and paint results.
// ----------------------------------------------------------------------------
interface spc_pix_if import spc_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_x;
	pix_t pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface spc_res_if import spc_pkg::*; ();
	logic valid;
	logic ready;
	logic paint;

	modport source (output valid, output paint, input ready);
	modport sink (input valid, input paint, output ready);
endinterface

// ===== sv/spc_tri_test.sv =====
// ----------------------------------------------------------------------------
// spc_tri_test
// Two-stage point-in-triangle test: box and products, then sign checks.
// ----------------------------------------------------------------------------
module spc_tri_test import spc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  trgl_t trgl,
	input  pix_t  px,
	input  pix_t  py,
	output logic  hit
);
	coord_t xmn, xmx, ymn, ymx, fx, fy;
	logic box;
	logic signed [DIFF_W-1:0] e1, e2, e3, e4, e5, e6, e7;
	logic signed [PROD_W-1:0] p_s1 [6];
	logic box_s1;
	logic signed [SUM_W-1:0] d, na, nb, ng;
	logic pos_ok, neg_ok;

	always_comb begin
		xmn = min3(trgl[0].x, trgl[1].x, trgl[2].x);
		xmx = max3(trgl[0].x, trgl[1].x, trgl[2].x);
		ymn = min3(trgl[0].y, trgl[1].y, trgl[2].y);
		ymx = max3(trgl[0].y, trgl[1].y, trgl[2].y);
		box = (px >= xmn[VERT_W-1:FRAC_BITS]) && (px < xmx[VERT_W-1:FRAC_BITS])
			&& (py >= ymn[VERT_W-1:FRAC_BITS]) && (py < ymx[VERT_W-1:FRAC_BITS]);
		fx = {px, {FRAC_BITS{1'b0}}};
		fy = {py, {FRAC_BITS{1'b0}}};
		e1 = DIFF_W'(trgl[1].y) - DIFF_W'(trgl[2].y);
		e2 = DIFF_W'(trgl[2].x) - DIFF_W'(trgl[1].x);
		e3 = DIFF_W'(trgl[0].x) - DIFF_W'(trgl[2].x);
		e4 = DIFF_W'(trgl[0].y) - DIFF_W'(trgl[2].y);
		e5 = DIFF_W'(trgl[2].y) - DIFF_W'(trgl[0].y);
		e6 = DIFF_W'(fx) - DIFF_W'(trgl[2].x);
		e7 = DIFF_W'(fy) - DIFF_W'(trgl[2].y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= e1 * e3;
			p_s1[1] <= e2 * e4;
			p_s1[2] <= e1 * e6;
			p_s1[3] <= e2 * e7;
			p_s1[4] <= e5 * e6;
			p_s1[5] <= e3 * e7;
			box_s1  <= box;
		end
	end

	// The denominator sign picks which side all three numerators must be on.
	always_comb begin
		d  = SUM_W'(p_s1[0]) + SUM_W'(p_s1[1]);
		na = SUM_W'(p_s1[2]) + SUM_W'(p_s1[3]);
		nb = SUM_W'(p_s1[4]) + SUM_W'(p_s1[5]);
		ng = d - na - nb;
		pos_ok = !na[SUM_W-1] && !nb[SUM_W-1] && !ng[SUM_W-1];
		neg_ok = (na[SUM_W-1] || na == '0) && (nb[SUM_W-1] || nb == '0)
			&& (ng[SUM_W-1] || ng == '0);
		hit = box_s1 && (d != '0) && (d[SUM_W-1] ? neg_ok : pos_ok);
	end
endmodule

// ===== sv/spc_cell.sv =====
// ----------------------------------------------------------------------------
// spc_cell
// One subdivision level: split, test the three corner children, descend.
// ----------------------------------------------------------------------------
module spc_cell import spc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  lvl_ctl_t ctl_in,
	input  trgl_t    trgl_in,
	output lvl_ctl_t ctl_out,
	output trgl_t    trgl_out
);
	vert_t m01, m12, m20;
	trgl_t kids [3];
	trgl_t kids_s1 [3];
	trgl_t parent_s1;
	lvl_ctl_t ctl_s1, nxt_ctl;
	trgl_t nxt_trgl;
	logic [2:0] hit;

	always_comb begin
		m01 = midpoint(trgl_in[0], trgl_in[1]);
		m12 = midpoint(trgl_in[1], trgl_in[2]);
		m20 = midpoint(trgl_in[2], trgl_in[0]);
		kids[0] = {m20, m01, trgl_in[0]};
		kids[1] = {m12, trgl_in[1], m01};
		kids[2] = {trgl_in[2], m12, m20};
	end

	for (genvar k = 0; k < 3; k++) begin : g_test
		spc_tri_test u_test (
			.clk  (clk),
			.en   (en),
			.trgl (kids[k]),
			.px   (ctl_in.px),
			.py   (ctl_in.py),
			.hit  (hit[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kids_s1   <= kids;
			parent_s1 <= trgl_in;
		end
	end

	// The first child in order that holds the pixel wins; none kills it.
	always_comb begin
		nxt_ctl  = ctl_s1;
		nxt_trgl = parent_s1;
		if (ctl_s1.left != '0) begin
			nxt_ctl.left = ctl_s1.left - 1'b1;
			if (ctl_s1.alive) begin
				priority if (hit[0]) begin
					nxt_trgl = kids_s1[0];
				end else if (hit[1]) begin
					nxt_trgl = kids_s1[1];
				end else if (hit[2]) begin
					nxt_trgl = kids_s1[2];
				end else begin
					nxt_ctl.alive = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= nxt_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trgl_out <= nxt_trgl;
		end
	end
endmodule

// ===== sv/sierpinski_pixel_classifier_core.sv =====
// ----------------------------------------------------------------------------
// sierpinski_pixel_classifier_core
// Decides per pixel whether a recursive Sierpinski rasterizer paints it.
// ----------------------------------------------------------------------------
// Usage: program the three outer vertices (unsigned Q11.12) and the depth
// through the APB port while no request is in flight. Registers sit at byte
// addresses 0x00 to 0x18 in the order A.x, A.y, B.x, B.y, C.x, C.y, depth;
// depths above twelve act as twelve. Writes take effect at the access cycle.
// Each request on the pixel channel carries one pixel column and row and
// gives exactly one result with the paint flag, in request order.
// The pixel runs down a chain of twelve identical level cells behind a
// front stage that tests the outer triangle for depth zero. Each cell
// forms the three children and their cross products, registers them,
// then checks the signs and hands the chosen child to the next cell.
// One request is taken every cycle while the receiver keeps up, so
// throughput is one pixel per cycle. When the receiver stalls, the whole
// chain holds and ready drops on the pixel channel until the waiting
// result is taken. Reset empties the chain at once and clears the control
// and configuration registers to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sierpinski_pixel_classifier_core import spc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	spc_pix_if.sink           pix,
	spc_res_if.source         res
);
	coord_t ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	depth_t depth_q, depth_sat;
	reg_idx_t reg_sel;
	logic en, front_hit, res_valid_q, paint_q;
	trgl_t outer;
	lvl_ctl_t front_s1;
	lvl_ctl_t chain_head;
	lvl_ctl_t ctl_chain [MAX_DEPTH+1];
	trgl_t trgl_chain [MAX_DEPTH+1];

	// Configuration registers; a write lands on the access cycle.
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[CFG_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q    <= '0;
			ay_q    <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			depth_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_AX:    ax_q    <= pwdata[VERT_W-1:0];
				REG_AY:    ay_q    <= pwdata[VERT_W-1:0];
				REG_BX:    bx_q    <= pwdata[VERT_W-1:0];
				REG_BY:    by_q    <= pwdata[VERT_W-1:0];
				REG_CX:    cx_q    <= pwdata[VERT_W-1:0];
				REG_CY:    cy_q    <= pwdata[VERT_W-1:0];
				REG_DEPTH: depth_q <= pwdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_AX:    prdata = CFG_DW'(ax_q);
			REG_AY:    prdata = CFG_DW'(ay_q);
			REG_BX:    prdata = CFG_DW'(bx_q);
			REG_BY:    prdata = CFG_DW'(by_q);
			REG_CX:    prdata = CFG_DW'(cx_q);
			REG_CY:    prdata = CFG_DW'(cy_q);
			REG_DEPTH: prdata = CFG_DW'(depth_q);
			default:   prdata = '0;
		endcase
	end

	assign depth_sat = (depth_q > DEPTH_LIMIT) ? DEPTH_LIMIT : depth_q;
	assign outer     = {{cx_q, cy_q}, {bx_q, by_q}, {ax_q, ay_q}};

	// The whole chain advances together unless a finished result is held.
	assign en        = !res_valid_q || res.ready;
	assign pix.ready = en;

	// Front stage: the outer triangle test only decides a depth of zero.
	spc_tri_test u_front (
		.clk  (clk),
		.en   (en),
		.trgl (outer),
		.px   (pix.pixel_x),
		.py   (pix.pixel_y),
		.hit  (front_hit)
	);

	// With no levels left the outer test is final, else the cells decide.
	always_comb begin
		chain_head       = front_s1;
		chain_head.alive = (front_s1.left == '0) ? front_hit : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1     <= '0;
			ctl_chain[0] <= '0;
		end else if (en) begin
			front_s1.valid <= pix.valid;
			front_s1.alive <= 1'b1;
			front_s1.left  <= depth_sat;
			front_s1.px    <= pix.pixel_x;
			front_s1.py    <= pix.pixel_y;
			ctl_chain[0]   <= chain_head;
		end
	end

	assign trgl_chain[0] = outer;

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		spc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (ctl_chain[i]),
			.trgl_in  (trgl_chain[i]),
			.ctl_out  (ctl_chain[i+1]),
			.trgl_out (trgl_chain[i+1])
		);
	end

	// Output register: a surviving pixel at the end of the chain is painted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			paint_q     <= 1'b0;
		end else if (en) begin
			res_valid_q <= ctl_chain[MAX_DEPTH].valid;
			paint_q     <= ctl_chain[MAX_DEPTH].alive;
		end
	end

	assign res.valid = res_valid_q;
	assign res.paint = paint_q;
endmodule

// ===== sv/spc_checker.sv =====
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks of the classifier's flow control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic paint
);
	// A held result keeps its flag until it is taken.
	`ASSERT_NXT(a_res_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(paint))
	// A stalled result stalls the request side in the same cycle.
	`ASSERT_IMP(a_stall_back, clk, arst_n, out_valid && !out_ready, !in_ready)
	// With no result waiting the block always takes a request.
	`ASSERT_IMP(a_free_ready, clk, arst_n, !out_valid, in_ready)
endmodule

bind sierpinski_pixel_classifier_core spc_checker u_spc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.paint     (res.paint)
);
